// ----- hw/rtl/shmh_pkg.sv -----
// Shared constants, types and command/status structs for the salted mixing hash.
package shmh_pkg;

    // Number of 32-bit state words (at least 8, since the digest reads words 0..7).
    localparam int STATE_WORDS   = 16;
    localparam int SW_BITS       = $clog2(STATE_WORDS);
    localparam int BLOCK_BYTES   = 32;
    localparam int BLOCK_WORDS   = 8;
    localparam int FINISH_ROUNDS = 12;
    localparam int ROUND_BITS    = $clog2(FINISH_ROUNDS);

    localparam logic [31:0] MIX_C1    = 32'h5bd1e995;
    localparam logic [31:0] MIX_C2    = 32'h1b873593;
    localparam logic [31:0] MIX_C3    = 32'hcc9e2d51;
    localparam logic [31:0] SEED_XOR  = 32'hdeadbeef;
    localparam logic [31:0] SEED_STEP = 32'h12345678;
    localparam logic [4:0]  FILL_START = 5'd16;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_FINAL = 2'd1,
        KIND_END   = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MIX_A,
        ST_WAIT_A,
        ST_WAIT_B,
        ST_FIN_A,
        ST_FIN_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_START_A,
        OP_START_B,
        OP_COMMIT,
        OP_START_F,
        OP_CLOSE
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [2:0] word_sel;
        logic [1:0] part_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic [4:0] fill;
        logic       mix_done;
    } dp_status_t;

endpackage

// ----- hw/rtl/shmh_mixer.sv -----
// Three-stage rotate-multiply mixer with one multiply per stage.
module shmh_mixer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] din,
    output logic        done,
    output logic [31:0] dout
);
    import shmh_pkg::*;

    logic [31:0] v1_reg, v2_reg, v3_reg;
    logic [31:0] v1_next, v2_next, v3_next;
    logic [2:0]  vld_reg;
    logic [2:0]  vld_next;
    logic [31:0] x1, x2, x3;

    // Each stage XORs in a rotated copy, then multiplies by its constant.
    always_comb
    begin
        x1       = din ^ {din[18:0], din[31:19]};
        v1_next  = x1 * MIX_C1;
        x2       = v1_reg ^ {v1_reg[14:0], v1_reg[31:15]};
        v2_next  = x2 * MIX_C2;
        x3       = v2_reg ^ {v2_reg[24:0], v2_reg[31:25]};
        v3_next  = x3 * MIX_C3;
        vld_next = {vld_reg[1:0], start};
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // Stage data.
    always_ff @(posedge clk)
    begin
        v1_reg <= v1_next;
        v2_reg <= v2_next;
        v3_reg <= v3_next;
    end

    assign done = vld_reg[2];
    assign dout = v3_reg;

endmodule

// ----- hw/rtl/shmh_datapath.sv -----
// Datapath: salt registers, state word ring, block byte buffer and the mixer.
module shmh_datapath (
    input  logic              clk,
    input  logic              rst_n,
    input  shmh_pkg::dp_cmd_t cmd,
    input  logic [1:0]        kind,
    input  logic [7:0]        data_byte,
    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [63:0]       cfg_data,
    output shmh_pkg::dp_status_t status,
    output logic [63:0]       digest_part
);
    import shmh_pkg::*;

    logic [63:0] salt_low_reg, salt_high_reg;
    logic [31:0] st_reg  [STATE_WORDS];
    logic [31:0] st_next [STATE_WORDS];
    logic [7:0]  bb_reg  [BLOCK_BYTES];
    logic [7:0]  bb_next [BLOCK_BYTES];
    logic        open_reg, open_next;
    logic [4:0]  fill_reg, fill_next;
    logic [4:0]  pos_eff;
    logic [31:0] seed;
    logic [31:0] blk_word;
    logic [7:0]  salt_b;
    logic        mix_start;
    logic [31:0] mix_in;
    logic        mix_done;
    logic [31:0] mix_out;
    logic [63:0] raw_part;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            salt_low_reg  <= '0;
            salt_high_reg <= '0;
        end
        else if (cfg_write)
        begin
            if (cfg_index)
            begin
                salt_high_reg <= cfg_data;
            end
            else
            begin
                salt_low_reg <= cfg_data;
            end
        end
    end

    assign pos_eff = open_reg ? fill_reg : FILL_START;
    assign seed    = SEED_XOR ^ salt_low_reg[31:0];

    // Block word with bytes past the fill position read as zero padding.
    always_comb
    begin
        for (int b = 0; b < 4; b++)
        begin
            if (fill_reg == 5'd0 || {cmd.word_sel, 2'(b)} < fill_reg)
            begin
                blk_word[8*b +: 8] = bb_reg[{cmd.word_sel, 2'(b)}];
            end
            else
            begin
                blk_word[8*b +: 8] = 8'd0;
            end
        end
        salt_b = 8'(salt_low_reg >> {cmd.word_sel, 3'b000});
    end

    // Mixer input selection.
    always_comb
    begin
        mix_start = 1'b0;
        mix_in    = st_reg[0] ^ st_reg[1];
        case (cmd.op)
            OP_START_A:
            begin
                mix_start = 1'b1;
                mix_in    = blk_word + {24'd0, salt_b} + st_reg[1];
            end
            OP_START_B:
            begin
                mix_start = 1'b1;
                mix_in    = st_reg[0] ^ mix_out;
            end
            OP_START_F:
            begin
                mix_start = 1'b1;
                mix_in    = st_reg[0] ^ st_reg[1];
            end
            default:
            begin
                mix_start = 1'b0;
            end
        endcase
    end

    shmh_mixer u_mixer (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mix_start),
        .din   (mix_in),
        .done  (mix_done),
        .dout  (mix_out)
    );

    // State ring, byte buffer and message bookkeeping.
    always_comb
    begin
        st_next   = st_reg;
        bb_next   = bb_reg;
        open_next = open_reg;
        fill_next = fill_reg;
        case (cmd.op)
            OP_ACCEPT:
            begin
                if (!open_reg)
                begin
                    for (int i = 0; i < STATE_WORDS; i++)
                    begin
                        st_next[i] = seed + 32'(SEED_STEP * i);
                    end
                    for (int i = 0; i < 8; i++)
                    begin
                        bb_next[i]     = salt_low_reg[8*i +: 8];
                        bb_next[i + 8] = salt_high_reg[8*i +: 8];
                    end
                    open_next = 1'b1;
                end
                if (kind_t'(kind) == KIND_END)
                begin
                    fill_next = pos_eff;
                end
                else
                begin
                    bb_next[pos_eff] = data_byte;
                    fill_next        = pos_eff + 5'd1;
                end
            end
            OP_COMMIT:
            begin
                for (int i = 0; i < STATE_WORDS - 1; i++)
                begin
                    st_next[i] = st_reg[i + 1];
                end
                st_next[STATE_WORDS - 1] = mix_out;
            end
            OP_CLOSE:
            begin
                open_next = 1'b0;
                fill_next = FILL_START;
            end
            default:
            begin
                open_next = open_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            fill_reg <= FILL_START;
        end
        else
        begin
            open_reg <= open_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        bb_reg <= bb_next;
    end

    // Digest slice selection with the salt folded into the first two slices.
    always_comb
    begin
        case (cmd.part_sel)
            2'd0:    raw_part = {st_reg[1], st_reg[0]} ^ salt_low_reg;
            2'd1:    raw_part = {st_reg[3], st_reg[2]} ^ salt_high_reg;
            2'd2:    raw_part = {st_reg[5], st_reg[4]};
            default: raw_part = {st_reg[7], st_reg[6]};
        endcase
    end

    assign digest_part     = raw_part;
    assign status.fill     = pos_eff;
    assign status.mix_done = mix_done;

endmodule

// ----- hw/rtl/shmh_ctrl.sv -----
// Controller: sequences block absorption, finishing rounds and digest output.
module shmh_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic [1:0]           kind,
    input  shmh_pkg::dp_status_t status,
    input  logic                 out_stall,
    output logic                 in_stall,
    output logic                 out_valid,
    output logic [1:0]           part_index,
    output logic                 last_part,
    output shmh_pkg::dp_cmd_t    cmd
);
    import shmh_pkg::*;

    state_t                state_reg, state_next;
    logic [2:0]            j_reg, j_next;
    logic [SW_BITS-1:0]    k_reg, k_next;
    logic [ROUND_BITS-1:0] round_reg, round_next;
    logic [1:0]            part_reg, part_next;
    logic                  finish_reg, finish_next;
    logic                  accept;
    logic                  k_last;
    logic [4:0]            new_fill;
    logic                  go_absorb;
    logic                  go_finish;

    assign accept   = in_valid && (state_reg == ST_IDLE) && (kind_t'(kind) != KIND_NONE);
    assign k_last   = (k_reg == SW_BITS'(STATE_WORDS - 1));
    assign new_fill = status.fill + 5'd1;

    // What an accepted item sets in motion.
    always_comb
    begin
        go_finish = (kind_t'(kind) != KIND_DATA);
        if (kind_t'(kind) == KIND_END)
        begin
            go_absorb = (status.fill != 5'd0);
        end
        else
        begin
            go_absorb = (new_fill == 5'd0) || (kind_t'(kind) == KIND_FINAL);
        end
    end

    // Next state and counters.
    always_comb
    begin
        state_next  = state_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        round_next  = round_reg;
        part_next   = part_reg;
        finish_next = finish_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    finish_next = go_finish;
                    j_next      = 3'd0;
                    k_next      = '0;
                    round_next  = '0;
                    part_next   = 2'd0;
                    if (go_absorb)
                    begin
                        state_next = ST_MIX_A;
                    end
                    else if (go_finish)
                    begin
                        state_next = ST_FIN_A;
                    end
                end
            end
            ST_MIX_A:
            begin
                state_next = ST_WAIT_A;
            end
            ST_WAIT_A:
            begin
                if (status.mix_done)
                begin
                    state_next = ST_WAIT_B;
                end
            end
            ST_WAIT_B:
            begin
                if (status.mix_done)
                begin
                    k_next = k_reg + 1'b1;
                    state_next = ST_MIX_A;
                    if (k_last)
                    begin
                        k_next = '0;
                        j_next = j_reg + 3'd1;
                        if (j_reg == 3'(BLOCK_WORDS - 1))
                        begin
                            state_next = finish_reg ? ST_FIN_A : ST_IDLE;
                        end
                    end
                end
            end
            ST_FIN_A:
            begin
                state_next = ST_FIN_WAIT;
            end
            ST_FIN_WAIT:
            begin
                if (status.mix_done)
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = ST_FIN_A;
                    if (k_last)
                    begin
                        k_next     = '0;
                        round_next = round_reg + 1'b1;
                        if (round_reg == ROUND_BITS'(FINISH_ROUNDS - 1))
                        begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    part_next = part_reg + 2'd1;
                    if (part_reg == 2'd3)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Commands and handshake outputs.
    always_comb
    begin
        cmd.op       = OP_NONE;
        cmd.word_sel = j_reg;
        cmd.part_sel = part_reg;
        case (state_reg)
            ST_IDLE:     cmd.op = accept ? OP_ACCEPT : OP_NONE;
            ST_MIX_A:    cmd.op = OP_START_A;
            ST_WAIT_A:   cmd.op = status.mix_done ? OP_START_B : OP_NONE;
            ST_WAIT_B:   cmd.op = status.mix_done ? OP_COMMIT : OP_NONE;
            ST_FIN_A:    cmd.op = OP_START_F;
            ST_FIN_WAIT: cmd.op = status.mix_done ? OP_COMMIT : OP_NONE;
            ST_OUT:      cmd.op = (!out_stall && part_reg == 2'd3) ? OP_CLOSE : OP_NONE;
            default:     cmd.op = OP_NONE;
        endcase
        in_stall   = (state_reg != ST_IDLE);
        out_valid  = (state_reg == ST_OUT);
        part_index = part_reg;
        last_part  = (part_reg == 2'd3);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            j_reg      <= '0;
            k_reg      <= '0;
            round_reg  <= '0;
            part_reg   <= '0;
            finish_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            round_reg  <= round_next;
            part_reg   <= part_next;
            finish_reg <= finish_next;
        end
    end

endmodule

// ----- hw/rtl/salted_hybrid_mixing_hash_unit.sv -----
// Top level of the salted mixing hash unit: controller plus datapath.
// The unit takes one message byte per item and returns four 64-bit digest items at
// message end. A byte that does not complete a 32-byte block leaves the unit idle.
// A completed or final block runs 8 x STATE_WORDS word updates through one shared
// three-stage multiply mixer, and the finishing pass runs 12 x STATE_WORDS mixes.
// No byte is taken from the start of absorption until the last digest item leaves.
// The four digest items follow at one per cycle while out_stall is low.
module salted_hybrid_mixing_hash_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_part,
    output logic [1:0]  part_index,
    output logic        last_part,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data
);
    import shmh_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Sequencer.
    shmh_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .kind       (kind),
        .status     (status),
        .out_stall  (out_stall),
        .in_stall   (in_stall),
        .out_valid  (out_valid),
        .part_index (part_index),
        .last_part  (last_part),
        .cmd        (cmd)
    );

    // Storage and arithmetic.
    shmh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .kind        (kind),
        .data_byte   (data_byte),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .status      (status),
        .digest_part (digest_part)
    );

endmodule

// ----- dv/salted_hybrid_mixing_hash_unit_test.sv -----
// Self-checking testbench for the salted mixing hash unit.
`timescale 1ns / 1ps

module salted_hybrid_mixing_hash_unit_test;
    import shmh_pkg::*;

    // Digest predictor and store of expected digest items.
    class digest_board;
        logic [63:0] salt_lo, salt_hi;
        logic [31:0] words [STATE_WORDS];
        logic [7:0]  blk [32];
        int          fill;
        bit          open_msg;
        logic [63:0] want_part [$];
        logic [1:0]  want_idx [$];
        logic        want_last [$];
        int          errors;

        function new();
            salt_lo = 0;
            salt_hi = 0;
            fill = 16;
            open_msg = 0;
            errors = 0;
            foreach (words[i]) words[i] = 0;
            foreach (blk[i]) blk[i] = 0;
        endfunction

        function logic [31:0] rotl(logic [31:0] v, int s);
            return (v << s) | (v >> (32 - s));
        endfunction

        function logic [31:0] mix(logic [31:0] v);
            v = v ^ rotl(v, 13);
            v = v * MIX_C1;
            v = v ^ rotl(v, 17);
            v = v * MIX_C2;
            v = v ^ rotl(v, 7);
            v = v * MIX_C3;
            return v;
        endfunction

        function logic [7:0] salt_at(int i);
            logic [63:0] w;
            w = (i < 8) ? salt_lo : salt_hi;
            return w[8 * (i % 8) +: 8];
        endfunction

        function void absorb();
            logic [31:0] w, s, nb;
            for (int j = 0; j < 8; j++) begin
                w = {blk[4*j+3], blk[4*j+2], blk[4*j+1], blk[4*j]};
                s = {24'd0, salt_at(j)};
                for (int k = 0; k < STATE_WORDS; k++) begin
                    nb = words[(k + 1) % STATE_WORDS];
                    words[k] = words[k] ^ mix(w + s + nb);
                    words[k] = mix(words[k]);
                end
            end
        endfunction

        function void finish();
            logic [63:0] v;
            if (fill != 0) begin
                for (int k = fill; k < 32; k++) blk[k] = 0;
                absorb();
            end
            for (int r = 0; r < FINISH_ROUNDS; r++)
                for (int k = 0; k < STATE_WORDS; k++)
                    words[k] = mix(words[k] ^ words[(k + 1) % STATE_WORDS]);
            for (int p = 0; p < 4; p++) begin
                v = {words[2*p+1], words[2*p]};
                if (p == 0) v = v ^ salt_lo;
                else if (p == 1) v = v ^ salt_hi;
                want_part.push_back(v);
                want_idx.push_back(p[1:0]);
                want_last.push_back(p == 3);
            end
            open_msg = 0;
            fill = 16;
        endfunction

        // Note one accepted input item.
        function void note_item(logic [1:0] k, logic [7:0] b);
            if (k == KIND_NONE) return;
            if (!open_msg) begin
                words[0] = SEED_XOR ^ salt_lo[31:0];
                for (int i = 1; i < STATE_WORDS; i++)
                    words[i] = words[i-1] + SEED_STEP;
                for (int i = 0; i < 16; i++) blk[i] = salt_at(i);
                fill = 16;
                open_msg = 1;
            end
            if (k == KIND_END) begin
                finish();
                return;
            end
            blk[fill] = b;
            fill = (fill + 1) % 32;
            if (fill == 0) absorb();
            if (k == KIND_FINAL) finish();
        endfunction

        // Check one accepted digest item against the oldest expectation.
        function void check_part(logic [63:0] d, logic [1:0] idx, logic lst);
            if (want_part.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected digest item %h", d);
                return;
            end
            if (d !== want_part[0] || idx !== want_idx[0] || lst !== want_last[0]) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h/%0d/%0d got %h/%0d/%0d",
                        want_part[0], want_idx[0], want_last[0], d, idx, lst);
            end
            void'(want_part.pop_front());
            void'(want_idx.pop_front());
            void'(want_last.pop_front());
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [1:0]  kind = 0;
    logic [7:0]  data_byte = 0;
    logic        out_valid;
    logic        out_stall = 1;
    logic [63:0] digest_part;
    logic [1:0]  part_index;
    logic        last_part;
    logic        cfg_write = 0;
    logic        cfg_index = 0;
    logic [63:0] cfg_data = 0;

    digest_board board = new();
    bit          sink_quiet = 0;

    salted_hybrid_mixing_hash_unit dut (.*);

    always #4 clk = ~clk;

    function int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    endfunction

    // Send one item and wait until it is accepted; valid stays high for a following item.
    task send_item(logic [1:0] k, logic [7:0] b, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        kind <= k;
        data_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_item(k, b);
    endtask

    task write_reg(logic idx, logic [63:0] v);
        cfg_write <= 1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        cfg_write <= 0;
        if (idx) board.salt_hi = v;
        else board.salt_lo = v;
        @(posedge clk);
    endtask

    task drain();
        in_valid <= 0;
        while (board.want_part.size() != 0) @(posedge clk);
        repeat (2000) @(posedge clk);
    endtask

    task send_message(int len, bit gaps);
        for (int i = 0; i < len - 1; i++) send_item(KIND_DATA, $urandom, gaps);
        if ($urandom_range(0, 4) == 0) send_item(KIND_END, $urandom, gaps);
        else send_item(KIND_FINAL, $urandom, gaps);
    endtask

    // Output side: random stalls, checking on every accepted digest item.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_part(digest_part, part_index, last_part);
        if (rst_n)
            out_stall <= sink_quiet ? 1'b0 : ($urandom_range(0, 9) < 3);
    end

    initial begin
        int n;
        repeat (11) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // Directed: empty message, kind 3, exact block ends, extremes.
        send_item(KIND_END, 8'hff, 0);
        send_item(KIND_NONE, 8'h55, 0);
        send_item(KIND_FINAL, 8'h00, 0);
        drain();
        write_reg(0, 64'hffff_ffff_ffff_ffff);
        write_reg(1, 64'hffff_ffff_ffff_ffff);
        for (int i = 0; i < 15; i++) send_item(KIND_DATA, 8'hff, 0);
        send_item(KIND_FINAL, 8'hff, 0);
        send_item(KIND_END, 8'h00, 0);
        drain();
        write_reg(0, 64'h0123_4567_89ab_cdef);
        write_reg(1, 64'hfedc_ba98_7654_3210);
        send_item(KIND_DATA, 8'h80, 0);
        send_item(KIND_NONE, 8'h01, 0);
        send_item(KIND_END, 8'h7f, 0);
        drain();
        // Random messages, short ones mostly, with salt changes between them.
        n = 0;
        while (n < 340) begin
            int len;
            if ($urandom_range(0, 3) == 0) begin
                // The salt only changes once the previous message has left the unit.
                drain();
                write_reg(0, {$urandom, $urandom});
                write_reg(1, {$urandom, $urandom});
            end
            sink_quiet = ($urandom_range(0, 3) == 0);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 18);
            if ($urandom_range(0, 9) == 0) begin
                send_item(KIND_NONE, $urandom, 1);
                n++;
            end
            send_message(len, !sink_quiet);
            n += len;
            if ($urandom_range(0, 2) == 0) drain();
        end
        drain();
        if (board.errors == 0 && board.want_part.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule
